// ----- rtl/pfa_pkg.sv -----
// Shared types, codes and sizes for the page frame allocator.
package pfa_pkg;

	localparam int NUM_PAGES = 4096;
	localparam int COUNT_W   = 16;
	localparam int PAGE_W    = $clog2(NUM_PAGES);
	localparam int FREE_W    = PAGE_W + 1;
	localparam int RSV_W     = 13;

	localparam logic [PAGE_W-1:0]  LAST_PAGE = PAGE_W'(NUM_PAGES - 1);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		F_ALLOC   = 3'd0,
		F_REF     = 3'd1,
		F_UNREF   = 3'd2,
		F_SHARE   = 3'd3,
		F_UNSHARE = 3'd4,
		F_SET_COW = 3'd5,
		F_CLR_COW = 3'd6,
		F_QUERY   = 3'd7
	} func_t;

	typedef enum logic [2:0] {
		ST_OK             = 3'd0,
		ST_EMPTY          = 3'd1,
		ST_NOT_USED       = 3'd2,
		ST_SHARED_RELEASE = 3'd3,
		ST_SHARE_ZERO     = 3'd4,
		ST_SATURATED      = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} pfa_state_t;

	typedef struct packed {
		logic [2:0]        func;
		logic [PAGE_W-1:0] page_index;
	} req_word_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [PAGE_W-1:0]  result_page;
		logic [COUNT_W-1:0] ref_after;
		logic [COUNT_W-1:0] share_after;
		logic               shared_mark;
		logic               cow_mark;
		logic               scrub_needed;
		logic [FREE_W-1:0]  free_total;
	} rsp_word_t;

	typedef struct packed {
		logic               used;
		logic               shared;
		logic               cow;
		logic [COUNT_W-1:0] ref_cnt;
		logic [COUNT_W-1:0] share_cnt;
	} page_entry_t;

	typedef struct packed {
		logic [COUNT_W-1:0] sum;
		logic               at_max;
		logic               is_zero;
		logic               is_one;
		logic               le_two;
	} alu_out_t;

endpackage

// ----- rtl/pfa_ram.sv -----
// Generic single write port, single registered read port RAM.
module pfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/pfa_alu.sv -----
// Shared count unit: increment or decrement, with at-max and range flags for saturation checks.
module pfa_alu
	import pfa_pkg::*;
(
	input  logic [COUNT_W-1:0] operand,
	input  logic               dec,
	output alu_out_t           res
);

	always_comb begin
		res.sum     = dec ? operand - COUNT_W'(1) : operand + COUNT_W'(1);
		res.at_max  = (operand == COUNT_MAX);
		res.is_zero = (operand == '0);
		res.is_one  = (operand == COUNT_W'(1));
		res.le_two  = (operand <= COUNT_W'(2));
	end

endmodule

// ----- rtl/page_frame_allocator_refcount.sv -----
// Top level: page frame allocator sequencer, free stack and page table.
//
//  port group   dir  handshake              carries
//  req_*        in   req_valid/req_ready    req_word (func, page_index)
//  rsp_*        out  rsp_valid/rsp_ready    rsp_word (status, counts, marks, free_total)
//  cfg_*        in   cfg_we                 cfg_wdata (reserved_low_pages)
//
// Each word first reads the page table and stack top, then updates them through
// the shared count unit and loads the response register.
// After reset and after every cfg_we the block sweeps all NUM_PAGES entries,
// one a cycle, rebuilding the stack; req_ready stays low meanwhile.
// A response held by rsp_ready low stalls only the update cycle of the next word.
module page_frame_allocator_refcount
	import pfa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_word_t        req_word,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_word_t        rsp_word,
	input  logic             cfg_we,
	input  logic [RSV_W-1:0] cfg_wdata
);

	pfa_state_t        state_q, state_d;
	logic [PAGE_W-1:0] clr_q;
	logic [FREE_W-1:0] free_q, free_d, free_cfg;
	req_word_t         req_q;
	logic              rsp_valid_q;
	rsp_word_t         rsp_q, rsp_d;

	logic                            accept, slot_free, exec_go;
	logic                            pg_we, stk_we;
	logic [PAGE_W-1:0]               pg_waddr, stk_waddr, stk_wdata, stk_rdata;
	page_entry_t                     pg_wdata, pg, nxt;
	logic [$bits(page_entry_t)-1:0]  pg_rdata;
	logic [COUNT_W-1:0]              alu_operand;
	logic                            alu_dec;
	alu_out_t                        alu;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign exec_go   = (state_q == S_EXEC) && slot_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;
	assign pg        = page_entry_t'(pg_rdata);

	assign free_cfg = (32'(cfg_wdata) >= NUM_PAGES) ? '0
		: FREE_W'(NUM_PAGES - 32'(cfg_wdata));

	pfa_ram #(.WIDTH($bits(page_entry_t)), .DEPTH(NUM_PAGES)) u_page_ram (
		.clk   (clk),
		.we    (pg_we),
		.waddr (pg_waddr),
		.wdata (pg_wdata),
		.re    (accept),
		.raddr (req_word.page_index),
		.rdata (pg_rdata)
	);

	pfa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (accept),
		.raddr (PAGE_W'(free_q - FREE_W'(1))),
		.rdata (stk_rdata)
	);

	always_comb begin
		unique case (func_t'(req_q.func))
			F_REF, F_UNREF: alu_operand = pg.ref_cnt;
			default:        alu_operand = pg.share_cnt;
		endcase
		alu_dec = (req_q.func == F_UNREF) || (req_q.func == F_UNSHARE);
	end

	pfa_alu u_alu (
		.operand (alu_operand),
		.dec     (alu_dec),
		.res     (alu)
	);

	always_comb begin
		nxt                = pg;
		free_d             = free_q;
		rsp_d              = '0;
		rsp_d.status       = ST_OK;
		rsp_d.result_page  = req_q.page_index;
		pg_we              = 1'b0;
		pg_waddr           = req_q.page_index;
		stk_we             = 1'b0;
		stk_waddr          = free_q[PAGE_W-1:0];
		stk_wdata          = req_q.page_index;

		unique case (func_t'(req_q.func))
			F_ALLOC: begin
				rsp_d.result_page = '0;
				if (free_q == '0) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					nxt               = '0;
					nxt.used          = 1'b1;
					nxt.ref_cnt       = COUNT_W'(1);
					free_d            = free_q - FREE_W'(1);
					pg_we             = exec_go;
					pg_waddr          = stk_rdata;
					rsp_d.result_page = stk_rdata;
					rsp_d.ref_after   = COUNT_W'(1);
				end
			end
			F_QUERY: begin
				rsp_d.result_page = '0;
			end
			default: begin
				pg_we = exec_go;
				if (!pg.used || pg.ref_cnt == '0) begin
					rsp_d.status = ST_NOT_USED;
				end else begin
					unique case (func_t'(req_q.func))
						F_REF: begin
							if (alu.at_max) rsp_d.status = ST_SATURATED;
							else nxt.ref_cnt = alu.sum;
						end
						F_UNREF: begin
							if (alu.is_one && pg.share_cnt != '0) begin
								rsp_d.status = ST_SHARED_RELEASE;
							end else begin
								nxt.ref_cnt = alu.sum;
								if (alu.is_one && 32'(free_q) < NUM_PAGES) begin
									nxt.used           = 1'b0;
									nxt.shared         = 1'b0;
									nxt.cow            = 1'b0;
									nxt.share_cnt      = '0;
									stk_we             = exec_go;
									free_d             = free_q + FREE_W'(1);
									rsp_d.scrub_needed = 1'b1;
								end
							end
						end
						F_SHARE: begin
							if (alu.at_max) begin
								rsp_d.status = ST_SATURATED;
							end else begin
								nxt.share_cnt = alu.sum;
								if (!alu.is_zero) nxt.shared = 1'b1;
							end
						end
						F_UNSHARE: begin
							if (alu.is_zero) begin
								rsp_d.status = ST_SHARE_ZERO;
							end else begin
								nxt.share_cnt = alu.sum;
								if (alu.le_two) nxt.shared = 1'b0;
							end
						end
						F_SET_COW: nxt.cow = 1'b1;
						default:   nxt.cow = 1'b0;
					endcase
				end
				rsp_d.ref_after   = nxt.ref_cnt;
				rsp_d.share_after = nxt.share_cnt;
				rsp_d.shared_mark = nxt.shared;
				rsp_d.cow_mark    = nxt.cow;
			end
		endcase
		rsp_d.free_total = free_d;
		pg_wdata         = nxt;

		if (state_q == S_CLEAR) begin
			pg_we     = 1'b1;
			pg_waddr  = clr_q;
			pg_wdata  = '0;
			stk_we    = 1'b1;
			stk_waddr = clr_q;
			stk_wdata = LAST_PAGE - clr_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == LAST_PAGE) state_d = S_IDLE;
			S_IDLE:  if (accept) state_d = S_EXEC;
			S_EXEC:  if (slot_free) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
		if (cfg_we) state_d = S_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			free_q      <= FREE_W'(NUM_PAGES);
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) clr_q <= '0;
			else if (state_q == S_CLEAR) clr_q <= clr_q + PAGE_W'(1);

			if (cfg_we) free_q <= free_cfg;
			else if (exec_go) free_q <= free_d;

			if (exec_go) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) req_q <= req_word;
		if (exec_go) rsp_q <= rsp_d;
	end

endmodule

// ----- test/tb_page_frame_allocator_refcount.sv -----
// Testbench for the page frame allocator: directed, reserved limit, share count, stall and random tests.
`timescale 1ns / 100ps

module tb_page_frame_allocator_refcount;
	import pfa_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	req_word_t        req_word;
	logic             rsp_valid;
	logic             rsp_ready;
	rsp_word_t        rsp_word;
	logic             cfg_we;
	logic [RSV_W-1:0] cfg_wdata;

	logic [PAGE_W-1:0]  stack_pages [NUM_PAGES];
	int unsigned        stack_depth;
	logic [COUNT_W-1:0] page_refs   [NUM_PAGES];
	logic [COUNT_W-1:0] page_shares [NUM_PAGES];
	bit                 pg_in_use      [NUM_PAGES];
	bit                 pg_shared_flag [NUM_PAGES];
	bit                 pg_cow_flag    [NUM_PAGES];
	logic [PAGE_W-1:0]  live_pages[$];

	rsp_word_t rsp_expected_q[$];
	bit        idle_gaps = 1'b1;
	int        rsp_hold_cycles = 0;
	bit        mismatch_seen = 1'b0;

	page_frame_allocator_refcount i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 5)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	function automatic void rebuild_allocator(input logic [RSV_W-1:0] rsv);
		int unsigned low;
		low = (rsv > NUM_PAGES) ? NUM_PAGES : rsv;
		for (int k = 0; k < NUM_PAGES; k++) begin
			page_refs[k]      = '0;
			page_shares[k]    = '0;
			pg_in_use[k]      = 1'b0;
			pg_shared_flag[k] = 1'b0;
			pg_cow_flag[k]    = 1'b0;
		end
		stack_depth = NUM_PAGES - low;
		for (int k = 0; k < stack_depth; k++)
			stack_pages[k] = PAGE_W'(NUM_PAGES - 1 - k);
		live_pages.delete();
	endfunction

	function automatic rsp_word_t predict_response(input func_t f, input logic [PAGE_W-1:0] pg);
		rsp_word_t r;
		logic [PAGE_W-1:0] p;
		r = '0;
		r.status = ST_OK;
		p = pg;
		if (f == F_QUERY) begin
			r.free_total = FREE_W'(stack_depth);
			return r;
		end
		if (f == F_ALLOC) begin
			if (stack_depth == 0) begin
				r.status = ST_EMPTY;
				return r;
			end
			stack_depth--;
			p = stack_pages[stack_depth];
			page_refs[p]      = COUNT_W'(1);
			page_shares[p]    = '0;
			pg_in_use[p]      = 1'b1;
			pg_shared_flag[p] = 1'b0;
			pg_cow_flag[p]    = 1'b0;
			live_pages.push_back(p);
		end else if (!pg_in_use[p] || page_refs[p] == 0) begin
			r.status = ST_NOT_USED;
		end else begin
			case (f)
				F_REF: begin
					if (page_refs[p] == COUNT_MAX)
						r.status = ST_SATURATED;
					else
						page_refs[p]++;
				end
				F_UNREF: begin
					if (page_refs[p] == 1 && page_shares[p] != 0) begin
						r.status = ST_SHARED_RELEASE;
					end else begin
						page_refs[p]--;
						if (page_refs[p] == 0 && stack_depth < NUM_PAGES) begin
							pg_in_use[p]      = 1'b0;
							pg_shared_flag[p] = 1'b0;
							pg_cow_flag[p]    = 1'b0;
							page_shares[p]    = '0;
							stack_pages[stack_depth] = p;
							stack_depth++;
							r.scrub_needed = 1'b1;
							for (int k = 0; k < live_pages.size(); k++)
								if (live_pages[k] == p) begin
									live_pages.delete(k);
									break;
								end
						end
					end
				end
				F_SHARE: begin
					if (page_shares[p] == COUNT_MAX) begin
						r.status = ST_SATURATED;
					end else begin
						page_shares[p]++;
						if (page_shares[p] > 1)
							pg_shared_flag[p] = 1'b1;
					end
				end
				F_UNSHARE: begin
					if (page_shares[p] == 0) begin
						r.status = ST_SHARE_ZERO;
					end else begin
						page_shares[p]--;
						if (page_shares[p] <= 1)
							pg_shared_flag[p] = 1'b0;
					end
				end
				F_SET_COW: pg_cow_flag[p] = 1'b1;
				default:   pg_cow_flag[p] = 1'b0;
			endcase
		end
		r.result_page = p;
		r.ref_after   = page_refs[p];
		r.share_after = page_shares[p];
		r.shared_mark = pg_shared_flag[p];
		r.cow_mark    = pg_cow_flag[p];
		r.free_total  = FREE_W'(stack_depth);
		return r;
	endfunction

	task automatic send_word(input func_t f, input logic [PAGE_W-1:0] pg);
		req_word_t w;
		int gap;
		gap = (idle_gaps && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w.func       = f;
		w.page_index = pg;
		req_word  <= w;
		req_valid <= 1'b1;
		rsp_expected_q.push_back(predict_response(f, pg));
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	task automatic finish_outstanding();
		req_valid <= 1'b0;
		while (rsp_expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reserved(input logic [RSV_W-1:0] v);
		finish_outstanding();
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		rebuild_allocator(v);
	endtask

	task automatic test_directed();
		send_word(F_QUERY, '1);
		send_word(F_ALLOC, '1);
		send_word(F_REF, '0);
		send_word(F_SHARE, '0);
		send_word(F_SHARE, '0);
		send_word(F_UNSHARE, '0);
		send_word(F_SET_COW, '0);
		send_word(F_CLR_COW, '0);
		send_word(F_SET_COW, '0);
		send_word(F_UNREF, '0);
		send_word(F_UNREF, '0);
		send_word(F_UNSHARE, '0);
		send_word(F_UNSHARE, '0);
		send_word(F_UNREF, '0);
		for (int f = int'(F_REF); f <= int'(F_CLR_COW); f++)
			send_word(func_t'(f), '1);
		send_word(F_REF, '0);
		send_word(F_ALLOC, '0);
		send_word(F_ALLOC, '1);
	endtask

	task automatic test_reserved_limits();
		write_reserved('1);
		send_word(F_ALLOC, '0);
		send_word(F_QUERY, '0);
		write_reserved(RSV_W'(NUM_PAGES));
		send_word(F_ALLOC, '0);
		write_reserved(RSV_W'(NUM_PAGES - 2));
		send_word(F_ALLOC, '0);
		send_word(F_ALLOC, '0);
		send_word(F_ALLOC, '0);
		send_word(F_UNREF, LAST_PAGE);
		send_word(F_ALLOC, '0);
		send_word(F_QUERY, '0);
		write_reserved('0);
	endtask

	task automatic test_backpressure();
		idle_gaps = 1'b0;
		rsp_hold_cycles = 300;
		for (int k = 0; k < 40; k++)
			send_word((k % 3 == 0) ? F_QUERY : F_ALLOC, PAGE_W'($urandom));
		finish_outstanding();
		idle_gaps = 1'b1;
	endtask

	task automatic test_share_counts();
		logic [PAGE_W-1:0] pg;
		idle_gaps = 1'b0;
		send_word(F_ALLOC, '0);
		pg = live_pages[$];
		for (int k = 0; k < 8; k++)
			send_word(F_REF, pg);
		for (int k = 0; k < 8; k++)
			send_word(F_SHARE, pg);
		send_word(F_UNSHARE, pg);
		for (int k = 0; k < 9; k++)
			send_word(F_UNREF, pg);
		for (int k = 0; k < 8; k++)
			send_word(F_UNSHARE, pg);
		send_word(F_UNREF, pg);
		idle_gaps = 1'b1;
	endtask

	task automatic test_random();
		logic [RSV_W-1:0] settings [4];
		int unsigned pick;
		settings[0] = RSV_W'(NUM_PAGES - 32);
		settings[1] = '0;
		settings[2] = RSV_W'($urandom_range(0, NUM_PAGES - 1));
		settings[3] = RSV_W'(NUM_PAGES - 8);
		for (int ph = 0; ph < 4; ph++) begin
			write_reserved(settings[ph]);
			for (int k = 0; k < 75; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 8)
					send_word(func_t'($urandom_range(0, 7)), PAGE_W'($urandom));
				else if (pick < 12)
					send_word(F_QUERY, PAGE_W'($urandom));
				else if (pick < 35 || live_pages.size() == 0)
					send_word(F_ALLOC, PAGE_W'($urandom));
				else
					send_word(func_t'($urandom_range(int'(F_REF), int'(F_CLR_COW))),
						live_pages[$urandom_range(0, live_pages.size() - 1)]);
			end
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_seen = 1'b1;
		end
	endfunction

	always @(posedge clk) begin : rsp_monitor
		rsp_word_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsp_expected_q.size() == 0) begin
				$error("response word with none expected");
				mismatch_seen = 1'b1;
			end else begin
				want = rsp_expected_q.pop_front();
				check_field("status", 32'(want.status), 32'(rsp_word.status));
				check_field("result_page", 32'(want.result_page),
					32'(rsp_word.result_page));
				check_field("ref_after", 32'(want.ref_after), 32'(rsp_word.ref_after));
				check_field("share_after", 32'(want.share_after),
					32'(rsp_word.share_after));
				check_field("shared_mark", 32'(want.shared_mark),
					32'(rsp_word.shared_mark));
				check_field("cow_mark", 32'(want.cow_mark), 32'(rsp_word.cow_mark));
				check_field("scrub_needed", 32'(want.scrub_needed),
					32'(rsp_word.scrub_needed));
				check_field("free_total", 32'(want.free_total),
					32'(rsp_word.free_total));
			end
		end
	end

	initial begin : rsp_drive
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold_cycles > 0) begin
				rsp_ready <= 1'b0;
				repeat (rsp_hold_cycles) @(posedge clk);
				rsp_hold_cycles = 0;
			end else if (idle_gaps && $urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
			end
			rsp_ready <= 1'b1;
		end
	end

	initial begin
		#5_000_000;
		$display("tb_page_frame_allocator_refcount: FAIL");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_word  <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		rebuild_allocator('0);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_reserved_limits();
		test_backpressure();
		test_share_counts();
		test_random();
		finish_outstanding();
		repeat (20) @(posedge clk);
		if (!mismatch_seen)
			$display("tb_page_frame_allocator_refcount: PASS");
		else
			$display("tb_page_frame_allocator_refcount: FAIL");
		$finish;
	end

endmodule
